[design/amt_pkg.sv]
// Shared types, codes and helper functions for the MMU translate block.
// Used by arm_mmu_translate_with_tlb_top; depends on nothing else.
package amt_pkg;

	// Default TLB geometry.
	localparam int AMT_BUCKETS = 16;
	localparam int AMT_WAYS    = 4;

	// Input opcodes.
	localparam logic [1:0] OP_XLATE  = 2'd0;
	localparam logic [1:0] OP_RETURN = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_DONE  = 2'd0;
	localparam logic [1:0] KIND_FAULT = 2'd1;
	localparam logic [1:0] KIND_REQ   = 2'd2;

	// Fault kinds.
	localparam logic [3:0] FK_NONE      = 4'd0;
	localparam logic [3:0] FK_ALIGN     = 4'd1;
	localparam logic [3:0] FK_L1_ABORT  = 4'd2;
	localparam logic [3:0] FK_SECT_XLAT = 4'd3;
	localparam logic [3:0] FK_L2_ABORT  = 4'd4;
	localparam logic [3:0] FK_PAGE_XLAT = 4'd5;
	localparam logic [3:0] FK_SECT_DOM  = 4'd6;
	localparam logic [3:0] FK_PAGE_DOM  = 4'd7;
	localparam logic [3:0] FK_SECT_PERM = 4'd8;
	localparam logic [3:0] FK_PAGE_PERM = 4'd9;

	// Configuration register indexes.
	localparam logic [2:0] CFG_XLATE_ON  = 3'd0;
	localparam logic [2:0] CFG_TBL_BASE  = 3'd1;
	localparam logic [2:0] CFG_DOM_ACC   = 3'd2;
	localparam logic [2:0] CFG_SYS_PROT  = 3'd3;
	localparam logic [2:0] CFG_ROM_PROT  = 3'd4;

	// Domain access codes.
	localparam logic [1:0] DC_NONE    = 2'd0;
	localparam logic [1:0] DC_CLIENT  = 2'd1;
	localparam logic [1:0] DC_RSVD    = 2'd2;
	localparam logic [1:0] DC_MANAGER = 2'd3;

	// Descriptor type codes.
	localparam logic [1:0] DT_FAULT = 2'd0;
	localparam logic [1:0] DT_T1    = 2'd1;
	localparam logic [1:0] DT_T2    = 2'd2;
	localparam logic [1:0] DT_T3    = 2'd3;

	// Mapping size of a cached entry.
	typedef enum logic [2:0] {
		SZ_NONE = 3'd0,
		SZ_1K   = 3'd1,
		SZ_4K   = 3'd2,
		SZ_16K  = 3'd3,
		SZ_64K  = 3'd4,
		SZ_1M   = 3'd5
	} size_code_t;

	// One TLB entry; va and pa are aligned to the mapping size.
	typedef struct packed {
		logic [31:0] va;
		logic [31:0] pa;
		size_code_t  szc;
		logic [1:0]  ap;
		logic [3:0]  dom;
		logic        sect;
	} tlb_ent_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] pa;
		logic [31:0] wa;
		logic [3:0]  fk;
		logic [3:0]  fd;
	} result_t;

	// Address bits that select the mapping of a given size.
	function automatic logic [31:0] size_mask(input size_code_t szc);
		logic [31:0] m;
		unique case (szc)
			SZ_1K:   m = 32'hFFFF_FC00;
			SZ_4K:   m = 32'hFFFF_F000;
			SZ_16K:  m = 32'hFFFF_C000;
			SZ_64K:  m = 32'hFFFF_0000;
			SZ_1M:   m = 32'hFFF0_0000;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// Domain and access permission check, then the final result.
	function automatic result_t check_access(input logic [31:0] dacr, input logic sbit,
		input logic rbit, input logic [31:0] adr, input tlb_ent_t e,
		input logic priv, input logic wr);
		result_t     r;
		logic [1:0]  dc;
		logic        bad;
		logic [31:0] m;
		r   = '0;
		dc  = dacr[{e.dom, 1'b0} +: 2];
		bad = 1'b0;
		m   = size_mask(e.szc);
		if (dc == DC_CLIENT) begin
			case (e.ap)
				2'd0:    bad = wr || (!rbit && (!priv || !sbit));
				2'd1:    bad = !priv;
				2'd2:    bad = !priv && wr;
				default: bad = 1'b0;
			endcase
		end
		if (dc == DC_NONE || dc == DC_RSVD) begin
			r.kind = KIND_FAULT;
			r.fk   = e.sect ? FK_SECT_DOM : FK_PAGE_DOM;
			r.fd   = e.dom;
		end else if (bad) begin
			r.kind = KIND_FAULT;
			r.fk   = e.sect ? FK_SECT_PERM : FK_PAGE_PERM;
			r.fd   = e.dom;
		end else begin
			r.kind = KIND_DONE;
			r.pa   = e.pa | (adr & ~m);
		end
		return r;
	endfunction

endpackage

[design/arm_mmu_translate_with_tlb_top.sv]
// Two-level page table MMU with a hashed set-associative TLB held in a synchronous memory.
// Steps: translation off, the address goes to the result register; TLB lookup, three hash
// steps, then a search of the ways one by one (1 to TLB_WAYS); a table read return, decoded.
// Throughput: one transaction at a time; a new one is taken once the result has left.
// Reset clears the entry valid bits, way pointers and walk state at once; no clearing pass.
// Depends on amt_pkg.
module arm_mmu_translate_with_tlb_top
	import amt_pkg::*;
#(
	parameter int TLB_BUCKETS = AMT_BUCKETS,
	parameter int TLB_WAYS    = AMT_WAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] virtual_address,
	input  logic        privileged,
	input  logic        write_access,
	input  logic [31:0] read_data,
	input  logic        read_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [31:0] physical_address,
	output logic [31:0] walk_read_address,
	output logic [3:0]  fault_kind,
	output logic [3:0]  fault_domain,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int BKW = (TLB_BUCKETS > 1) ? $clog2(TLB_BUCKETS) : 1;
	localparam int WW  = (TLB_WAYS > 1) ? $clog2(TLB_WAYS) : 1;
	localparam int CW  = $clog2(TLB_WAYS + 1);
	localparam int RW  = $clog2(2 * TLB_BUCKETS) + 1;
	localparam int HK  = 30;
	localparam logic [30:0] HMUL = 31'((64'd1 << HK) / TLB_BUCKETS);
	localparam logic [8:0]  BDIV = 9'(TLB_BUCKETS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HASH = 4'b0010,
		ST_LOOK = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		WP_IDLE = 3'b001,
		WP_L1   = 3'b010,
		WP_L2   = 3'b100
	} wphase_t;

	state_t      state_q;
	wphase_t     wphase_q;
	logic        ton_q;
	logic [31:0] tbase_q;
	logic [31:0] dacr_q;
	logic        sbit_q;
	logic        rbit_q;
	logic [31:0] adr_q;
	logic        priv_q;
	logic        wr_q;
	logic [BKW-1:0] bkt_q;
	logic [WW-1:0]  way_q;
	logic [CW-1:0]  wcnt_q;
	logic [21:0]    hash_q;
	logic [21:0]    quo_q;
	logic [RW-1:0]  rem_q;
	logic [1:0]     hcnt_q;
	logic [3:0]     wdom_q;
	logic           coarse_q;
	result_t        res_q;
	logic           valid_q [TLB_BUCKETS][TLB_WAYS];
	logic [WW-1:0]  repl_q [TLB_BUCKETS];
	logic [WW-1:0]  lhit_q [TLB_BUCKETS];

	tlb_ent_t tlb_mem [TLB_BUCKETS][TLB_WAYS];
	tlb_ent_t rd_q;

	logic           in_acc;
	logic           flush;
	logic [21:0]    hx;
	logic [21:0]    hash22;
	logic [52:0]    hprod;
	logic [30:0]    hqb;
	logic [RW-1:0]  rem_nxt;
	logic [BKW-1:0] hbkt;
	logic           hit;
	logic           last_way;
	logic [WW-1:0]  way_dn;
	logic           mem_re;
	logic [BKW-1:0] rd_bkt;
	logic [WW-1:0]  rd_way;
	logic           mem_we;
	logic [WW-1:0]  wway;
	logic           wk_fin;
	tlb_ent_t       wk_ent;
	result_t        wk_res;
	result_t        wk_out;
	wphase_t        wk_phase;
	logic [3:0]     wk_dom;
	logic           wk_coarse;

	// Handshake.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);

	assign result_kind       = res_q.kind;
	assign physical_address  = res_q.pa;
	assign walk_read_address = res_q.wa;
	assign fault_kind        = res_q.fk;
	assign fault_domain      = res_q.fd;

	// Writes of the enable or the table base, and flush transactions, clear the TLB.
	assign flush = (cfg_we && (cfg_index == CFG_XLATE_ON || cfg_index == CFG_TBL_BASE)) ||
		(in_acc && opcode == OP_FLUSH);

	// Bucket hash. The remainder takes one step per cycle: a reciprocal multiply for the
	// quotient estimate, a back multiply and subtract, then one correcting subtract.
	assign hx     = virtual_address[31:10];
	assign hash22 = hx ^ (hx >> 5) ^ (hx >> 10);

	assign hprod   = 53'(hash_q) * 53'(HMUL);
	assign hqb     = 31'(quo_q) * 31'(BDIV);
	assign rem_nxt = RW'(hash_q) - RW'(hqb);
	assign hbkt    = (rem_q >= RW'(TLB_BUCKETS)) ? BKW'(rem_q - RW'(TLB_BUCKETS))
		: BKW'(rem_q);

	// Way search compare against the registered read data.
	assign hit      = valid_q[bkt_q][way_q] && ((adr_q & size_mask(rd_q.szc)) == rd_q.va);
	assign last_way = (wcnt_q == CW'(TLB_WAYS - 1));
	assign way_dn   = (way_q == '0) ? WW'(TLB_WAYS - 1) : way_q - 1'b1;

	// Memory read address: first way after hashing, then the next way down.
	always_comb begin
		mem_re = 1'b0;
		rd_bkt = bkt_q;
		rd_way = way_dn;
		if (state_q == ST_HASH && hcnt_q == 2'd2) begin
			mem_re = 1'b1;
			rd_bkt = hbkt;
			rd_way = lhit_q[hbkt];
		end else if (state_q == ST_LOOK && !hit && !last_way) begin
			mem_re = 1'b1;
		end
	end

	// Descriptor decode for a table read return.
	always_comb begin
		logic [31:0] t;
		logic [7:0]  aps;
		logic [1:0]  sub;
		logic        tex;
		logic        full;
		t         = read_data;
		aps       = t[11:4];
		sub       = 2'd0;
		tex       = 1'b0;
		full      = 1'b0;
		wk_fin    = 1'b0;
		wk_ent    = '0;
		wk_res    = '0;
		wk_phase  = WP_IDLE;
		wk_dom    = wdom_q;
		wk_coarse = coarse_q;
		if (wphase_q == WP_L1) begin
			if (!read_ok) begin
				wk_res.kind = KIND_FAULT;
				wk_res.fk   = FK_L1_ABORT;
			end else begin
				case (t[1:0])
					DT_FAULT: begin
						wk_res.kind = KIND_FAULT;
						wk_res.fk   = FK_SECT_XLAT;
					end
					DT_T2: begin
						wk_fin = 1'b1;
						wk_ent = '{va: adr_q & 32'hFFF0_0000, pa: t & 32'hFFF0_0000,
							szc: SZ_1M, ap: t[11:10], dom: t[8:5], sect: 1'b1};
					end
					DT_T1: begin
						wk_coarse   = 1'b1;
						wk_dom      = t[8:5];
						wk_phase    = WP_L2;
						wk_res.kind = KIND_REQ;
						wk_res.wa   = (t & 32'hFFFF_FC00) + ((adr_q & 32'h000F_F000) >> 10);
					end
					default: begin
						wk_coarse   = 1'b0;
						wk_dom      = t[8:5];
						wk_phase    = WP_L2;
						wk_res.kind = KIND_REQ;
						wk_res.wa   = (t & 32'hFFFF_F000) + ((adr_q & 32'h000F_FC00) >> 8);
					end
				endcase
			end
		end else begin
			if (!read_ok) begin
				wk_res.kind = KIND_FAULT;
				wk_res.fk   = FK_L2_ABORT;
				wk_res.fd   = wdom_q;
			end else if (t[1:0] == DT_FAULT) begin
				wk_res.kind = KIND_FAULT;
				wk_res.fk   = FK_PAGE_XLAT;
				wk_res.fd   = wdom_q;
			end else if (t[1:0] == DT_T3 && !coarse_q) begin
				// Tiny page.
				wk_fin = 1'b1;
				wk_ent = '{va: adr_q & 32'hFFFF_FC00, pa: t & 32'hFFFF_FC00,
					szc: SZ_1K, ap: t[5:4], dom: wdom_q, sect: 1'b0};
			end else begin
				wk_fin = 1'b1;
				tex    = (t[1:0] == DT_T3);
				full   = tex || (aps[3:0] == aps[7:4] && aps[1:0] == aps[3:2]);
				if (t[1:0] == DT_T1) begin
					// Large page, cached whole or as one quarter.
					sub = adr_q[15:14];
					if (full) begin
						wk_ent = '{va: adr_q & 32'hFFFF_0000, pa: t & 32'hFFFF_0000,
							szc: SZ_64K, ap: aps[1:0], dom: wdom_q, sect: 1'b0};
					end else begin
						wk_ent = '{va: adr_q & 32'hFFFF_C000,
							pa: (t & 32'hFFFF_0000) | {16'd0, sub, 14'd0},
							szc: SZ_16K, ap: aps[{sub, 1'b0} +: 2], dom: wdom_q,
							sect: 1'b0};
					end
				end else begin
					// Small page, or an extended page in a coarse table.
					sub = adr_q[11:10];
					if (full) begin
						wk_ent = '{va: adr_q & 32'hFFFF_F000, pa: t & 32'hFFFF_F000,
							szc: SZ_4K, ap: aps[1:0], dom: wdom_q, sect: 1'b0};
					end else begin
						wk_ent = '{va: adr_q & 32'hFFFF_FC00,
							pa: (t & 32'hFFFF_F000) | {20'd0, sub, 10'd0},
							szc: SZ_1K, ap: aps[{sub, 1'b0} +: 2], dom: wdom_q,
							sect: 1'b0};
					end
				end
			end
		end
		wk_out = wk_fin ? check_access(dacr_q, sbit_q, rbit_q, adr_q, wk_ent, priv_q, wr_q)
			: wk_res;
	end

	assign wway   = repl_q[bkt_q];
	assign mem_we = in_acc && opcode == OP_RETURN && wphase_q != WP_IDLE && wk_fin;

	// TLB entry memory with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tlb_mem[bkt_q][wway] <= wk_ent;
		end
		if (mem_re) begin
			rd_q <= tlb_mem[rd_bkt][rd_way];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ton_q   <= 1'b0;
			tbase_q <= '0;
			dacr_q  <= '0;
			sbit_q  <= 1'b0;
			rbit_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_XLATE_ON: ton_q   <= cfg_data[0];
				CFG_TBL_BASE: tbase_q <= cfg_data;
				CFG_DOM_ACC:  dacr_q  <= cfg_data;
				CFG_SYS_PROT: sbit_q  <= cfg_data[0];
				CFG_ROM_PROT: rbit_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, walk state and TLB bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wphase_q <= WP_IDLE;
			adr_q    <= '0;
			priv_q   <= 1'b0;
			wr_q     <= 1'b0;
			wdom_q   <= '0;
			coarse_q <= 1'b0;
			bkt_q    <= '0;
			way_q    <= '0;
			wcnt_q   <= '0;
			hcnt_q   <= '0;
			for (int b = 0; b < TLB_BUCKETS; b++) begin
				repl_q[b] <= '0;
				lhit_q[b] <= '0;
				for (int w = 0; w < TLB_WAYS; w++) begin
					valid_q[b][w] <= 1'b0;
				end
			end
		end else begin
			if (flush) begin
				for (int b = 0; b < TLB_BUCKETS; b++) begin
					repl_q[b] <= '0;
					lhit_q[b] <= '0;
					for (int w = 0; w < TLB_WAYS; w++) begin
						valid_q[b][w] <= 1'b0;
					end
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && opcode == OP_XLATE) begin
						wphase_q <= WP_IDLE;
						adr_q    <= virtual_address;
						priv_q   <= privileged;
						wr_q     <= write_access;
						if (!ton_q) begin
							state_q <= ST_OUT;
						end else begin
							hcnt_q  <= '0;
							state_q <= ST_HASH;
						end
					end else if (in_acc && opcode == OP_RETURN && wphase_q != WP_IDLE) begin
						wphase_q <= wk_phase;
						wdom_q   <= wk_dom;
						coarse_q <= wk_coarse;
						if (wk_fin) begin
							valid_q[bkt_q][wway] <= 1'b1;
							lhit_q[bkt_q]        <= wway;
							repl_q[bkt_q]        <= (wway == WW'(TLB_WAYS - 1)) ? '0
								: wway + 1'b1;
						end
						state_q <= ST_OUT;
					end
				end
				ST_HASH: begin
					hcnt_q <= hcnt_q + 1'b1;
					if (hcnt_q == 2'd2) begin
						bkt_q   <= hbkt;
						way_q   <= lhit_q[hbkt];
						wcnt_q  <= '0;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (hit) begin
						lhit_q[bkt_q] <= way_q;
						state_q       <= ST_OUT;
					end else if (last_way) begin
						if (tbase_q[1:0] == 2'd0) begin
							wphase_q <= WP_L1;
						end
						state_q <= ST_OUT;
					end else begin
						way_q  <= way_dn;
						wcnt_q <= wcnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hash remainder and result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && opcode == OP_XLATE) begin
			hash_q <= hash22;
			res_q  <= '{kind: KIND_DONE, pa: virtual_address, wa: 32'd0, fk: FK_NONE,
				fd: 4'd0};
		end else if (state_q == ST_IDLE && in_acc && opcode == OP_RETURN) begin
			res_q <= wk_out;
		end else if (state_q == ST_HASH) begin
			if (hcnt_q == 2'd0) begin
				quo_q <= hprod[HK +: 22];
			end
			if (hcnt_q == 2'd1) begin
				rem_q <= rem_nxt;
			end
		end else if (state_q == ST_LOOK) begin
			if (hit) begin
				res_q <= check_access(dacr_q, sbit_q, rbit_q, adr_q, rd_q, priv_q, wr_q);
			end else if (tbase_q[1:0] != 2'd0) begin
				res_q <= '{kind: KIND_FAULT, pa: 32'd0, wa: 32'd0, fk: FK_ALIGN, fd: 4'd0};
			end else begin
				res_q <= '{kind: KIND_REQ, pa: 32'd0,
					wa: tbase_q + {18'd0, adr_q[31:20], 2'b00}, fk: FK_NONE, fd: 4'd0};
			end
		end
	end

	// The way search never runs past the last way of the bucket.
	a_wcnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |-> wcnt_q < CW'(TLB_WAYS))
		else $error("way search ran past the bucket");

	// No TLB write while a lookup reads the memory.
	a_we_look: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_IDLE)
		else $error("TLB write outside idle");

	// A table read request always leaves a walk pending.
	a_req_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && res_q.kind == KIND_REQ) |-> wphase_q != WP_IDLE)
		else $error("read request without pending walk");

	// The second level is entered only from the first.
	a_l2_from_l1: assert property (@(posedge clk) disable iff (!arst_n)
		(wphase_q == WP_L2 && $past(wphase_q) != WP_L2) |-> $past(wphase_q) == WP_L1)
		else $error("second level entered out of order");

endmodule
